[hdl/iff_pkg.sv]
`default_nettype none
package iff_pkg;

	// lengths of the field and of its parts, up to 64 characters
	localparam int LEN_W = 7;

	localparam logic [1:0] BASE_OCT = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_MEASURE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic measure;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic in_dec;
		logic empty;
		logic last;
		logic out_free;
	} sts_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'd0, d};
		end else begin
			c = (lower ? CH_LOWER_A : CH_UPPER_A) + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[hdl/iff_ctrl.sv]
`default_nettype none
module iff_ctrl #(
	parameter int VALUE_BITS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire iff_pkg::sts_t sts,
	output iff_pkg::cmd_t      cmd
);
	import iff_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS);

	state_t state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic conv_done;

	assign conv_done = (cnt_q == CNT_W'(VALUE_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = sts.in_dec ? ST_CONV : ST_MEASURE;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_nx = ST_MEASURE;
				end
			end
			ST_MEASURE: begin
				state_nx = sts.empty ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free && sts.last) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_CONV:    cmd.step    = 1'b1;
			ST_MEASURE: cmd.measure = 1'b1;
			ST_EMIT:    cmd.emit    = sts.out_free;
			default:    cmd         = '0;
		endcase
	end

endmodule
`default_nettype wire

[hdl/iff_datapath.sv]
`default_nettype none
module iff_datapath #(
	parameter int MAX_CHARS  = 64,
	parameter int VALUE_BITS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          kind,
	input  wire logic [63:0]   value,
	input  wire logic [1:0]    base_select,
	input  wire logic          upper_case,
	input  wire logic [5:0]    field_width,
	input  wire logic [5:0]    min_digits,
	input  wire logic          pad_zero,
	input  wire logic          align_left,
	input  wire logic          force_plus,
	input  wire logic          force_space,
	input  wire iff_pkg::cmd_t cmd,
	output iff_pkg::sts_t      sts,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_char,
	output logic               last_char
);
	import iff_pkg::*;

	localparam int NDIG  = (VALUE_BITS + 2) / 3;
	localparam int EXT_W = 4 * NDIG;
	localparam int IW    = $clog2(NDIG);
	localparam int LIMIT = (MAX_CHARS < 64) ? MAX_CHARS : 64;

	// operand and options
	logic [VALUE_BITS-1:0]  mag_q;
	logic [NDIG-1:0][3:0]   digits_q;
	logic                   lower_q;
	logic [7:0]             sign_q;
	logic                   has_sign_q;
	logic [5:0]             width_q;
	logic [5:0]             prec_q;
	logic                   zpad_q;
	logic                   left_q;

	// field layout
	logic [LEN_W-1:0] n_q, ds_q, de_q, pad_q, p_q;

	logic [7:0] out_char_q;
	logic       last_q;
	logic       out_valid_q;

	// load
	logic [VALUE_BITS-1:0] raw, mag;
	logic [EXT_W-1:0]      ext;
	logic                  neg;
	logic [NDIG-1:0][3:0]  direct;

	always_comb begin
		raw = value[VALUE_BITS-1:0];
		neg = kind & raw[VALUE_BITS-1];
		mag = neg ? (VALUE_BITS'(0) - raw) : raw;
		ext = EXT_W'(mag);
		for (int i = 0; i < NDIG; i++) begin
			if (base_select == BASE_OCT) begin
				direct[i] = {1'b0, ext[3*i +: 3]};
			end else begin
				direct[i] = ext[4*i +: 4];
			end
		end
	end

	// double dabble: add three to every bcd digit of five or more, then shift
	logic [NDIG-1:0][3:0] adj;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (digits_q[i] >= 4'd5) ? digits_q[i] + 4'd3 : digits_q[i];
		end
	end

	// measure
	logic [LEN_W-1:0] tnd, nd, numlen, wid, padv, tot, n_nx, ds_nx;

	always_comb begin
		tnd = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (digits_q[i] != 4'd0) begin
				tnd = LEN_W'(i + 1);
			end
		end
		nd     = (tnd > {1'b0, prec_q}) ? tnd : {1'b0, prec_q};
		numlen = nd + {{(LEN_W-1){1'b0}}, has_sign_q};
		wid    = {1'b0, width_q};
		padv   = (wid > numlen) ? wid - numlen : '0;
		tot    = numlen + padv;
		n_nx   = (tot > LEN_W'(LIMIT)) ? LEN_W'(LIMIT) : tot;
		ds_nx  = {{(LEN_W-1){1'b0}}, has_sign_q} + (left_q ? '0 : padv);
	end

	// character at the current position
	logic [LEN_W-1:0] k;
	logic [3:0]       dval;
	logic [7:0]       ch;

	always_comb begin
		k    = de_q - p_q - 1'b1;
		dval = (k < LEN_W'(NDIG)) ? digits_q[k[IW-1:0]] : 4'd0;
		priority if (p_q < ds_q) begin
			if (left_q) begin
				ch = sign_q;
			end else if (zpad_q) begin
				ch = (p_q == '0 && has_sign_q) ? sign_q : CH_ZERO;
			end else begin
				ch = (p_q < pad_q) ? CH_SPACE : sign_q;
			end
		end else if (p_q < de_q) begin
			ch = digit_char(dval, lower_q);
		end else begin
			ch = CH_SPACE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q   <= mag;
			lower_q <= kind | ~upper_case;
			width_q <= field_width;
			prec_q  <= min_digits;
			zpad_q  <= pad_zero;
			left_q  <= align_left;
			if (base_select == BASE_DEC) begin
				digits_q <= '0;
			end else begin
				digits_q <= direct;
			end
			has_sign_q <= kind & (neg | force_plus | force_space);
			if (neg) begin
				sign_q <= CH_MINUS;
			end else if (force_plus) begin
				sign_q <= CH_PLUS;
			end else begin
				sign_q <= CH_SPACE;
			end
		end
		if (cmd.step) begin
			digits_q <= EXT_W'({adj, mag_q[VALUE_BITS-1]});
			mag_q    <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
		if (cmd.measure) begin
			n_q   <= n_nx;
			ds_q  <= ds_nx;
			de_q  <= ds_nx + nd;
			pad_q <= padv;
			p_q   <= '0;
		end
		if (cmd.emit) begin
			out_char_q <= ch;
			last_q     <= (p_q == n_q - 1'b1);
			p_q        <= p_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.in_dec   = (base_select == BASE_DEC);
	assign sts.empty    = (n_nx == '0);
	assign sts.last     = (p_q == n_q - 1'b1);
	assign sts.out_free = ~out_valid_q | ~out_stall;

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

endmodule
`default_nettype wire

[hdl/integer_field_formatter.sv]
`default_nettype none
// Formats one integer per input item as a printf-style field (signed or unsigned, octal,
// decimal or hex, width, precision, zero padding, left alignment, forced sign) and sends it
// out one ASCII character per output item, with last_char on the final one. An empty field
// gives no output. A field holds at most min(MAX_CHARS, 64) characters. Decimal digits come
// from a double-dabble converter that shifts one operand bit per cycle, and the output
// register takes one character per cycle while the receiver does not stall. A new item is
// taken once the previous field has been handed to the output register, while its last
// character may still wait.
module integer_field_formatter #(
	parameter int MAX_CHARS  = 64,
	parameter int VALUE_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [63:0] value,
	input  wire logic [1:0]  base_select,
	input  wire logic        upper_case,
	input  wire logic [5:0]  field_width,
	input  wire logic [5:0]  min_digits,
	input  wire logic        pad_zero,
	input  wire logic        align_left,
	input  wire logic        force_plus,
	input  wire logic        force_space,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_char,
	output logic             last_char
);
	import iff_pkg::*;

	cmd_t cmd;
	sts_t sts;

	iff_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	iff_datapath #(
		.MAX_CHARS (MAX_CHARS),
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (kind),
		.value      (value),
		.base_select(base_select),
		.upper_case (upper_case),
		.field_width(field_width),
		.min_digits (min_digits),
		.pad_zero   (pad_zero),
		.align_left (align_left),
		.force_plus (force_plus),
		.force_space(force_space),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.last_char  (last_char)
	);

endmodule
`default_nettype wire

[hdl/iff_checker.sv]
`default_nettype none
module iff_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_char,
	input wire logic       last_char
);

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_char))
		else $error("output item changed while stalled");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

	// no new item while a field is still being sent
	a_no_accept_mid_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_char |-> in_stall)
		else $error("input ready in the middle of a field");

	// characters of one field follow without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_char |=> out_valid)
		else $error("gap inside a field");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_char (out_char),
	.last_char(last_char)
);
`default_nettype wire

[test/iff_field_checker.sv]
`timescale 1ns / 1ps
module iff_field_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        kind,
	input  logic [63:0] value,
	input  logic [1:0]  base_select,
	input  logic        upper_case,
	input  logic [5:0]  field_width,
	input  logic [5:0]  min_digits,
	input  logic        pad_zero,
	input  logic        align_left,
	input  logic        force_plus,
	input  logic        force_space,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_char,
	input  logic        last_char,
	output int          errors,
	output int          pending,
	output int          items_seen,
	output int          chars_seen,
	output int          empty_seen
);
	import iff_pkg::*;

	localparam int FIELD_CAP = 64;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} field_char_t;

	field_char_t exp_chars [$];

	int err_cnt;
	int item_cnt;
	int char_cnt;
	int empty_cnt;

	// builds the expected field of one item and queues its characters
	function automatic int format_field(
		input logic        sgnd,
		input logic [63:0] v,
		input logic [1:0]  bsel,
		input logic        upper,
		input logic [5:0]  width,
		input logic [5:0]  prec,
		input logic        zpad,
		input logic        left,
		input logic        fplus,
		input logic        fspace
	);
		logic [63:0] mag;
		logic [63:0] radix;
		logic [63:0] rem;
		logic [7:0]  sgn;
		logic        has_sign;
		logic        lower;
		logic [7:0]  rev [0:71];
		logic [7:0]  text [$];
		int          nd;
		int          numlen;
		int          pad;
		int          n;
		mag = v;
		has_sign = 1'b0;
		sgn = CH_SPACE;
		lower = !upper;
		if (sgnd) begin
			lower = 1'b1;
			if (v[63]) begin
				mag = ~v + 64'd1;
				sgn = CH_MINUS;
				has_sign = 1'b1;
			end else if (fplus) begin
				sgn = CH_PLUS;
				has_sign = 1'b1;
			end else if (fspace) begin
				sgn = CH_SPACE;
				has_sign = 1'b1;
			end
		end
		if (bsel == BASE_OCT)
			radix = 64'd8;
		else if (bsel == BASE_DEC)
			radix = 64'd10;
		else
			radix = 64'd16;
		nd = 0;
		while (mag != 64'd0 && nd < 64) begin
			rem = mag % radix;
			if (rem < 64'd10)
				rev[nd] = CH_ZERO + rem[7:0];
			else
				rev[nd] = (lower ? CH_LOWER_A : CH_UPPER_A) + rem[7:0] - 8'd10;
			nd++;
			mag = mag / radix;
		end
		while (nd < int'(prec)) begin
			rev[nd] = CH_ZERO;
			nd++;
		end
		numlen = nd + (has_sign ? 1 : 0);
		pad = (int'(width) > numlen) ? int'(width) - numlen : 0;
		if (!left) begin
			if (zpad && has_sign)
				text.push_back(sgn);
			repeat (pad) text.push_back(zpad ? CH_ZERO : CH_SPACE);
			if (!zpad && has_sign)
				text.push_back(sgn);
		end else if (has_sign) begin
			text.push_back(sgn);
		end
		for (int j = nd - 1; j >= 0; j--)
			text.push_back(rev[j]);
		if (left)
			repeat (pad) text.push_back(CH_SPACE);
		n = (text.size() > FIELD_CAP) ? FIELD_CAP : text.size();
		for (int j = 0; j < n; j++)
			exp_chars.push_back('{ch: text[j], last: (j == n - 1)});
		return n;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		field_char_t e;
		int          n;
		if (!arst_n) begin
			exp_chars.delete();
			err_cnt = 0;
			item_cnt = 0;
			char_cnt = 0;
			empty_cnt = 0;
			errors <= 0;
			pending <= 0;
			items_seen <= 0;
			chars_seen <= 0;
			empty_seen <= 0;
		end else begin
			// output side first: a char leaving now always belongs to an older item
			if (out_valid && !out_stall) begin
				char_cnt++;
				if (exp_chars.size() == 0) begin
					$display("%0t: char with nothing expected: expected none, actual %h last %b",
						$time, out_char, last_char);
					err_cnt++;
				end else begin
					e = exp_chars.pop_front();
					if (out_char !== e.ch) begin
						$display("%0t: out_char mismatch: expected %h, actual %h",
							$time, e.ch, out_char);
						err_cnt++;
					end
					if (last_char !== e.last) begin
						$display("%0t: last_char mismatch: expected %b, actual %b",
							$time, e.last, last_char);
						err_cnt++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				item_cnt++;
				n = format_field(kind, value, base_select, upper_case, field_width,
					min_digits, pad_zero, align_left, force_plus, force_space);
				if (n == 0)
					empty_cnt++;
			end
			errors <= err_cnt;
			pending <= exp_chars.size();
			items_seen <= item_cnt;
			chars_seen <= char_cnt;
			empty_seen <= empty_cnt;
		end
	end

endmodule

[test/tb_integer_field_formatter.sv]
`timescale 1ns / 1ps
module tb_integer_field_formatter;
	import iff_pkg::*;

	localparam logic [1:0] BASE_HEX = 2'd2;
	localparam logic [1:0] BASE_ALT = 2'd3;   // unused code, decodes as hex
	localparam logic       KIND_UNS = 1'b0;
	localparam logic       KIND_SGN = 1'b1;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int RANDOM_ITEMS = 306;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 200;
	localparam int LIMIT_CYCLES = 2000000;

	typedef struct packed {
		logic        kind;
		logic [63:0] value;
		logic [1:0]  bsel;
		logic        upper;
		logic [5:0]  width;
		logic [5:0]  prec;
		logic        zpad;
		logic        left;
		logic        fplus;
		logic        fspace;
	} fmt_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic [63:0] value = '0;
	logic [1:0]  base_select = '0;
	logic        upper_case = 1'b0;
	logic [5:0]  field_width = '0;
	logic [5:0]  min_digits = '0;
	logic        pad_zero = 1'b0;
	logic        align_left = 1'b0;
	logic        force_plus = 1'b0;
	logic        force_space = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_char;
	logic        last_char;

	int errors;
	int pending;
	int items_seen;
	int chars_seen;
	int empty_seen;
	int cycle_count = 0;
	int hold_req = 0;
	bit calm = 1'b0;

	integer_field_formatter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value       (value),
		.base_select (base_select),
		.upper_case  (upper_case),
		.field_width (field_width),
		.min_digits  (min_digits),
		.pad_zero    (pad_zero),
		.align_left  (align_left),
		.force_plus  (force_plus),
		.force_space (force_space),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_char   (last_char)
	);

	iff_field_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.value       (value),
		.base_select (base_select),
		.upper_case  (upper_case),
		.field_width (field_width),
		.min_digits  (min_digits),
		.pad_zero    (pad_zero),
		.align_left  (align_left),
		.force_plus  (force_plus),
		.force_space (force_space),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_char   (last_char),
		.errors      (errors),
		.pending     (pending),
		.items_seen  (items_seen),
		.chars_seen  (chars_seen),
		.empty_seen  (empty_seen)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d chars still expected", cycle_count, pending);
			$display("integer_field_formatter regression: fail");
			$finish;
		end
	end

	function automatic fmt_req_t mk_req(
		input logic        k,
		input logic [63:0] v,
		input logic [1:0]  b,
		input logic        up,
		input logic [5:0]  w,
		input logic [5:0]  p,
		input logic        zp,
		input logic        lf,
		input logic        fp,
		input logic        fs
	);
		return '{kind: k, value: v, bsel: b, upper: up, width: w, prec: p,
			zpad: zp, left: lf, fplus: fp, fspace: fs};
	endfunction

	function automatic fmt_req_t rand_req();
		fmt_req_t r;
		r.kind = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0: r.value = '0;
			1: r.value = 64'($urandom_range(0, 40));
			2: r.value = ALL_ONES - 64'($urandom_range(0, 40));
			3: begin
				case ($urandom_range(0, 3))
					0: r.value = MOST_NEG;
					1: r.value = MOST_POS;
					2: r.value = ALL_ONES;
					default: r.value = MOST_NEG + 64'($urandom_range(0, 3));
				endcase
			end
			4: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
			default: r.value = {$urandom, $urandom};
		endcase
		r.bsel = 2'($urandom_range(0, 3));
		r.upper = 1'($urandom_range(0, 1));
		// mostly short fields so the run stays quick
		r.width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
			: 6'($urandom_range(0, 16));
		case ($urandom_range(0, 4))
			0, 1: r.prec = '0;
			2, 3: r.prec = 6'($urandom_range(1, 8));
			default: r.prec = 6'($urandom_range(0, 63));
		endcase
		r.zpad = 1'($urandom_range(0, 1));
		r.left = 1'($urandom_range(0, 1));
		r.fplus = 1'($urandom_range(0, 1));
		r.fspace = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic send_item(input fmt_req_t r);
		kind <= r.kind;
		value <= r.value;
		base_select <= r.bsel;
		upper_case <= r.upper;
		field_width <= r.width;
		min_digits <= r.prec;
		pad_zero <= r.zpad;
		align_left <= r.left;
		force_plus <= r.fplus;
		force_space <= r.fspace;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// receiver: random stall bursts, and one long hold-off when asked
	initial begin : receiver
		int hold_seen;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		fmt_req_t directed [$];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero with no precision: empty field, then a single digit
		directed.push_back(mk_req(KIND_UNS, '0, BASE_DEC, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_UNS, '0, BASE_DEC, 0, 0, 1, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_SGN, '0, BASE_HEX, 0, 0, 0, 1, 0, 0, 0));
		// largest unsigned in every base
		directed.push_back(mk_req(KIND_UNS, ALL_ONES, BASE_DEC, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_UNS, ALL_ONES, BASE_OCT, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_UNS, ALL_ONES, BASE_HEX, 1, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_UNS, 64'hDEAD_BEEF_CAFE_F00D, BASE_HEX, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_UNS, 64'hABCD_EF01_2345_6789, BASE_ALT, 1, 0, 0, 0, 0, 0, 0));
		// most negative and extremes of the signed kind
		directed.push_back(mk_req(KIND_SGN, MOST_NEG, BASE_DEC, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_SGN, MOST_NEG, BASE_HEX, 1, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_SGN, ALL_ONES, BASE_OCT, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_SGN, MOST_POS, BASE_DEC, 0, 0, 0, 0, 0, 1, 0));
		// forced signs, and their being ignored when unsigned
		directed.push_back(mk_req(KIND_SGN, 64'd42, BASE_DEC, 0, 0, 0, 0, 0, 0, 1));
		directed.push_back(mk_req(KIND_SGN, 64'd42, BASE_DEC, 0, 0, 0, 0, 0, 1, 1));
		directed.push_back(mk_req(KIND_UNS, 64'd42, BASE_DEC, 0, 0, 0, 0, 0, 1, 1));
		directed.push_back(mk_req(KIND_SGN, '0, BASE_DEC, 0, 5, 0, 0, 0, 0, 1));
		// widest fields and padding layouts
		directed.push_back(mk_req(KIND_UNS, 64'd1, BASE_DEC, 0, 63, 0, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_SGN, ALL_ONES - 64'd6, BASE_DEC, 0, 63, 0, 1, 0, 0, 0));
		directed.push_back(mk_req(KIND_SGN, 64'd77, BASE_OCT, 0, 20, 0, 1, 1, 1, 0));
		directed.push_back(mk_req(KIND_SGN, MOST_NEG, BASE_HEX, 0, 63, 63, 0, 0, 0, 0));
		directed.push_back(mk_req(KIND_UNS, 64'hFFF, BASE_HEX, 1, 63, 63, 1, 1, 0, 0));
		directed.push_back(mk_req(KIND_UNS, 64'd123456, BASE_DEC, 0, 3, 0, 1, 0, 0, 0));
		directed.push_back(mk_req(KIND_SGN, 64'd9, BASE_DEC, 0, 12, 6, 1, 0, 0, 1));
		directed.push_back(mk_req(KIND_SGN, ALL_ONES, BASE_DEC, 0, 10, 4, 0, 1, 0, 0));

		foreach (directed[i]) begin
			send_item(directed[i]);
			maybe_gap();
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100)
				hold_req = hold_req + 1;
			if (i == 200) begin
				// let everything come out before going on
				in_valid <= 1'b0;
				drain();
			end
			if (i == RANDOM_ITEMS - 40)
				calm = 1'b1;
			send_item(rand_req());
			maybe_gap();
		end
		in_valid <= 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d items (%0d empty fields) and %0d chars", items_seen, empty_seen,
			chars_seen);
		$display("over all bases, both kinds, forced signs, padding and alignment modes");
		if (errors == 0 && pending == 0)
			$display("integer_field_formatter regression: pass");
		else
			$display("integer_field_formatter regression: fail");
		$finish;
	end

endmodule
